// ===== src/pvt_pkg.sv =====
`default_nettype none
package pvt_pkg;

  localparam int COORD_W = 16;
  localparam int ANGLE_W = 12;
  localparam int DEPTH_W = 16;
  localparam int DIM_W   = 13;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 2;

  // quarter-wave polynomial, Q2.30
  localparam int T_W    = 31;
  localparam int PW     = 32;
  localparam int TSH    = 32 - ANGLE_W;
  localparam int PSH    = 30;
  localparam int RND_SH = 18;
  localparam logic [PW-1:0] SIN_COEF [5] = '{
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  localparam int TRIG_W = 15;
  localparam int FRAC   = 12;
  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int RSUM_W = PROD_W + 1;
  localparam int XR_W   = RSUM_W - FRAC;
  localparam int ZT_W   = XR_W + 1;
  localparam int PSUM_W = ZT_W + 1;
  localparam int NUM_W  = PSUM_W + DIM_W + 1;
  localparam int MAG_W  = NUM_W;
  localparam int DEN_W  = ZT_W + 1;
  localparam int SX_W   = MAG_W + 2;

  localparam int IN_TDATA_W  = ((3 * COORD_W + ANGLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * OUT_W;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DEPTH  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  // per-lane divider result
  typedef struct packed {
    logic [MAG_W-1:0] quo;
    logic             rem_nz;
    logic             neg;
  } divres_t;

endpackage
`default_nettype wire

// ===== src/pvt_sincos.sv =====
`default_nettype none
module pvt_sincos (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               adv,
  input  wire logic                               in_vld,
  input  wire pvt_pkg::vtx_t                      in_vtx,
  input  wire logic [pvt_pkg::ANGLE_W-1:0]        in_angle,
  output logic                                    out_vld,
  output pvt_pkg::vtx_t                           out_vtx,
  output logic signed [pvt_pkg::TRIG_W-1:0]       out_sin,
  output logic signed [pvt_pkg::TRIG_W-1:0]       out_cos
);
  import pvt_pkg::*;

  localparam int NS = 7;
  localparam logic [ANGLE_W-2:0] QUARTER = (ANGLE_W-1)'(1) << (ANGLE_W - 2);

  logic [NS-1:0]          vld_r;
  vtx_t                   vtx_r [NS];
  logic [T_W-1:0]         t_r   [NS][2];
  logic [PW-1:0]          t2_r  [NS][2];
  logic [PW-1:0]          p_r   [NS][2];
  logic                   neg_r [NS][2];
  logic signed [TRIG_W-1:0] trig_r [2];

  logic [ANGLE_W-1:0]     ang   [2];
  logic [ANGLE_W-2:0]     rr    [2];
  logic [T_W-1:0]         t_nxt [2];
  logic [2*T_W-1:0]       sq    [2];
  logic [2*PW-1:0]        pm    [NS][2];
  logic [T_W+PW-1:0]      fm    [2];
  logic [PW:0]            fv    [2];
  logic [PW:0]            fr    [2];
  logic [TRIG_W-2:0]      mag   [2];

  // lane 0 is sine, lane 1 is cosine (sine a quarter turn ahead)
  always_comb begin
    ang[0] = in_angle;
    ang[1] = in_angle + ANGLE_W'(QUARTER);
    for (int l = 0; l < 2; l++) begin
      rr[l] = {1'b0, ang[l][ANGLE_W-3:0]};
      if (ang[l][ANGLE_W-2]) begin
        rr[l] = QUARTER - rr[l];
      end
      t_nxt[l] = T_W'(rr[l]) << TSH;
      sq[l]    = t_r[0][l] * t_r[0][l];
      fm[l]    = t_r[NS-2][l] * p_r[NS-2][l];
      fv[l]    = fm[l][PSH +: PW+1];
      fr[l]    = (fv[l] + (PW+1)'(1 << (RND_SH - 1))) >> RND_SH;
      mag[l]   = fr[l][TRIG_W-2:0];
    end
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < 2; l++) begin
        pm[k][l] = '0;
      end
    end
    for (int k = 2; k < NS-1; k++) begin
      for (int l = 0; l < 2; l++) begin
        pm[k][l] = t2_r[k-1][l] * ((k == 2) ? SIN_COEF[0] : p_r[k-1][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vtx_r[0] <= in_vtx;
      for (int l = 0; l < 2; l++) begin
        t_r[0][l]   <= t_nxt[l];
        neg_r[0][l] <= ang[l][ANGLE_W-1];
        t2_r[0][l]  <= '0;
        p_r[0][l]   <= '0;
        p_r[1][l]   <= '0;
      end
      for (int k = 1; k < NS; k++) begin
        vtx_r[k] <= vtx_r[k-1];
        for (int l = 0; l < 2; l++) begin
          t_r[k][l]   <= t_r[k-1][l];
          neg_r[k][l] <= neg_r[k-1][l];
          t2_r[k][l]  <= (k == 1) ? sq[l][PSH +: PW] : t2_r[k-1][l];
        end
      end
      for (int k = 2; k < NS-1; k++) begin
        for (int l = 0; l < 2; l++) begin
          p_r[k][l] <= SIN_COEF[k-1] - pm[k][l][PSH +: PW];
        end
      end
      for (int l = 0; l < 2; l++) begin
        p_r[NS-1][l] <= p_r[NS-2][l];
        trig_r[l] <= neg_r[NS-2][l] ? -$signed({1'b0, mag[l]}) : $signed({1'b0, mag[l]});
      end
    end
  end

  assign out_vld = vld_r[NS-1];
  assign out_vtx = vtx_r[NS-1];
  assign out_sin = trig_r[0];
  assign out_cos = trig_r[1];

endmodule
`default_nettype wire

// ===== src/pvt_rotate.sv =====
`default_nettype none
module pvt_rotate (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               adv,
  input  wire logic                               in_vld,
  input  wire pvt_pkg::vtx_t                      in_vtx,
  input  wire logic signed [pvt_pkg::TRIG_W-1:0]  in_sin,
  input  wire logic signed [pvt_pkg::TRIG_W-1:0]  in_cos,
  input  wire logic signed [pvt_pkg::DEPTH_W-1:0] depth,
  input  wire logic [pvt_pkg::DIM_W-1:0]          height,
  output logic                                    out_vld,
  output logic signed [pvt_pkg::NUM_W-1:0]        out_nx,
  output logic signed [pvt_pkg::NUM_W-1:0]        out_ny,
  output logic [pvt_pkg::DEN_W-1:0]               out_den,
  output logic                                    out_behind
);
  import pvt_pkg::*;

  logic [2:0] vld_r;
  logic signed [PROD_W-1:0] pxc_r, pzs_r, pxs_r, pzc_r;
  logic signed [COORD_W-1:0] y0_r, y1_r;
  logic signed [XR_W-1:0] xr_r;
  logic signed [ZT_W-1:0] zt_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic [DEN_W-1:0] den_r;
  logic behind_r;

  logic signed [RSUM_W-1:0] xs, zs, xsh, zsh;
  logic signed [PSUM_W-1:0] sa, sb;
  logic signed [DIM_W:0] hs;

  always_comb begin
    xs  = RSUM_W'(pxc_r) - RSUM_W'(pzs_r) + RSUM_W'(1 << (FRAC - 1));
    zs  = RSUM_W'(pxs_r) + RSUM_W'(pzc_r) + RSUM_W'(1 << (FRAC - 1));
    xsh = xs >>> FRAC;
    zsh = zs >>> FRAC;
    sa  = PSUM_W'(xr_r) + PSUM_W'(zt_r);
    sb  = PSUM_W'(zt_r) - PSUM_W'(y1_r);
    hs  = $signed({1'b0, height});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxc_r <= in_vtx.x * in_cos;
      pzs_r <= in_vtx.z * in_sin;
      pxs_r <= in_vtx.x * in_sin;
      pzc_r <= in_vtx.z * in_cos;
      y0_r  <= in_vtx.y;
      xr_r  <= XR_W'(xsh);
      zt_r  <= ZT_W'(XR_W'(zsh)) + ZT_W'(depth);
      y1_r  <= y0_r;
      nx_r  <= sa * hs;
      ny_r  <= sb * hs;
      den_r <= {zt_r, 1'b0};
      behind_r <= zt_r[ZT_W-1] || (zt_r == '0);
    end
  end

  assign out_vld    = vld_r[2];
  assign out_nx     = nx_r;
  assign out_ny     = ny_r;
  assign out_den    = den_r;
  assign out_behind = behind_r;

endmodule
`default_nettype wire

// ===== src/pvt_div.sv =====
`default_nettype none
module pvt_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             adv,
  input  wire logic                             in_vld,
  input  wire logic signed [pvt_pkg::NUM_W-1:0] in_nx,
  input  wire logic signed [pvt_pkg::NUM_W-1:0] in_ny,
  input  wire logic [pvt_pkg::DEN_W-1:0]        in_den,
  input  wire logic                             in_behind,
  output logic                                  out_vld,
  output pvt_pkg::divres_t                      out_x,
  output pvt_pkg::divres_t                      out_y,
  output logic                                  out_behind
);
  import pvt_pkg::*;

  // one quotient bit per stage, restoring, both lanes side by side
  localparam int NS = MAG_W + 1;

  logic [NS-1:0]     vld_r;
  logic [MAG_W-1:0]  num_r [NS][2];
  logic [DEN_W-1:0]  rem_r [NS][2];
  logic              neg_r [NS][2];
  logic [DEN_W-1:0]  den_r [NS];
  logic [NS-1:0]     bhd_r;

  logic signed [NUM_W-1:0] nin [2];
  logic [DEN_W:0]          sh  [NS][2];
  logic                    ge  [NS][2];

  always_comb begin
    nin[0] = in_nx;
    nin[1] = in_ny;
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < 2; l++) begin
        sh[k][l] = '0;
        ge[k][l] = 1'b0;
      end
    end
    for (int k = 1; k < NS; k++) begin
      for (int l = 0; l < 2; l++) begin
        sh[k][l] = {rem_r[k-1][l], num_r[k-1][l][MAG_W-1]};
        ge[k][l] = sh[k][l] >= {1'b0, den_r[k-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= in_den;
      bhd_r[0] <= in_behind;
      for (int l = 0; l < 2; l++) begin
        neg_r[0][l] <= nin[l][NUM_W-1];
        num_r[0][l] <= nin[l][NUM_W-1] ? MAG_W'(-nin[l]) : MAG_W'(nin[l]);
        rem_r[0][l] <= '0;
      end
      for (int k = 1; k < NS; k++) begin
        den_r[k] <= den_r[k-1];
        bhd_r[k] <= bhd_r[k-1];
        for (int l = 0; l < 2; l++) begin
          neg_r[k][l] <= neg_r[k-1][l];
          num_r[k][l] <= {num_r[k-1][l][MAG_W-2:0], ge[k][l]};
          rem_r[k][l] <= ge[k][l] ? DEN_W'(sh[k][l] - {1'b0, den_r[k-1]})
                                  : DEN_W'(sh[k][l]);
        end
      end
    end
  end

  assign out_vld    = vld_r[NS-1];
  assign out_behind = bhd_r[NS-1];
  assign out_x      = '{quo: num_r[NS-1][0], rem_nz: |rem_r[NS-1][0], neg: neg_r[NS-1][0]};
  assign out_y      = '{quo: num_r[NS-1][1], rem_nz: |rem_r[NS-1][1], neg: neg_r[NS-1][1]};

endmodule
`default_nettype wire

// ===== src/perspective_vertex_transform.sv =====
`default_nettype none
// Rotates a Q4.12 vertex about the vertical axis, adds the depth offset and
// projects it to pixel coordinates, one vertex per clock while out_tready does not
// hold the output. The result comes out through 48 register stages: 7 for
// the sine/cosine polynomial, 3 for rotation and scaling, 37 for the pipelined
// one-bit-per-stage divider, and 1 for rounding and saturation into the
// output register. The whole pipeline advances together; it holds
// while a result waits on out_tready. Config writes take effect at once and
// belong in idle periods.
module perspective_vertex_transform (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // vertex_x, vertex_y, vertex_z, rotation_angle, zero pad
  input  wire logic [pvt_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // screen_x, screen_y
  output logic [pvt_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // behind_viewer, clipped
  output logic [1:0]                                out_tuser,
  input  wire logic                                 cfg_we,
  input  wire logic [pvt_pkg::CFG_AW-1:0]           cfg_addr,
  input  wire logic [pvt_pkg::CFG_W-1:0]            cfg_wdata
);
  import pvt_pkg::*;

  logic signed [DEPTH_W-1:0] depth_r;
  logic [DIM_W-1:0] width_r, height_r;

  logic adv;
  vtx_t in_vtx;
  logic sc_vld, rot_vld, div_vld, div_behind;
  vtx_t sc_vtx;
  logic signed [TRIG_W-1:0] sc_sin, sc_cos;
  logic signed [NUM_W-1:0] rot_nx, rot_ny;
  logic [DEN_W-1:0] rot_den;
  logic rot_behind;
  divres_t div_x, div_y;

  logic out_vld_r;
  logic [OUT_W-1:0] sx_r, sy_r;
  logic behind_r, clip_r;

  logic signed [DIM_W:0] diff;
  logic signed [DIM_W:0] offs;
  logic signed [SX_W-1:0] vx, vy, fx, fy;
  logic [OUT_W-1:0] sx_nxt, sy_nxt;
  logic ovx, ovy;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign in_vtx    = '{x: in_tdata[COORD_W-1:0],
                       y: in_tdata[2*COORD_W-1:COORD_W],
                       z: in_tdata[3*COORD_W-1:2*COORD_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= DEPTH_W'(4096);
      width_r  <= DIM_W'(1024);
      height_r <= DIM_W'(768);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEPTH:  depth_r  <= cfg_wdata[DEPTH_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  pvt_sincos u_sincos (
    .clk, .rst_n, .adv,
    .in_vld   (in_tvalid),
    .in_vtx   (in_vtx),
    .in_angle (in_tdata[3*COORD_W +: ANGLE_W]),
    .out_vld  (sc_vld),
    .out_vtx  (sc_vtx),
    .out_sin  (sc_sin),
    .out_cos  (sc_cos)
  );

  pvt_rotate u_rotate (
    .clk, .rst_n, .adv,
    .in_vld     (sc_vld),
    .in_vtx     (sc_vtx),
    .in_sin     (sc_sin),
    .in_cos     (sc_cos),
    .depth      (depth_r),
    .height     (height_r),
    .out_vld    (rot_vld),
    .out_nx     (rot_nx),
    .out_ny     (rot_ny),
    .out_den    (rot_den),
    .out_behind (rot_behind)
  );

  pvt_div u_div (
    .clk, .rst_n, .adv,
    .in_vld     (rot_vld),
    .in_nx      (rot_nx),
    .in_ny      (rot_ny),
    .in_den     (rot_den),
    .in_behind  (rot_behind),
    .out_vld    (div_vld),
    .out_x      (div_x),
    .out_y      (div_y),
    .out_behind (div_behind)
  );

  // floor division from magnitude quotient; offset truncates toward zero
  always_comb begin
    diff = $signed({1'b0, width_r}) - $signed({1'b0, height_r});
    offs = (diff + $signed((DIM_W+1)'(diff[DIM_W]))) >>> 1;
    vx = $signed({2'b0, div_x.quo}) + SX_W'(div_x.rem_nz && div_x.neg);
    vy = $signed({2'b0, div_y.quo}) + SX_W'(div_y.rem_nz && div_y.neg);
    fx = (div_x.neg ? -vx : vx) + SX_W'(offs);
    fy = div_y.neg ? -vy : vy;
    ovx = !((&fx[SX_W-1:OUT_W-1]) || !(|fx[SX_W-1:OUT_W-1]));
    ovy = !((&fy[SX_W-1:OUT_W-1]) || !(|fy[SX_W-1:OUT_W-1]));
    sx_nxt = ovx ? {fx[SX_W-1], {(OUT_W-1){!fx[SX_W-1]}}} : fx[OUT_W-1:0];
    sy_nxt = ovy ? {fy[SX_W-1], {(OUT_W-1){!fy[SX_W-1]}}} : fy[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r     <= div_behind ? '0 : sx_nxt;
      sy_r     <= div_behind ? '0 : sy_nxt;
      behind_r <= div_behind;
      clip_r   <= !div_behind && (ovx || ovy);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {sy_r, sx_r};
  assign out_tuser  = {clip_r, behind_r};

  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("behind-viewer result not zeroed");

  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[15:0] == 16'h7fff || out_tdata[15:0] == 16'h8000 ||
      out_tdata[31:16] == 16'h7fff || out_tdata[31:16] == 16'h8000)
    else $error("clipped flag without a saturated coordinate");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

endmodule
`default_nettype wire

// ===== dv/pvt_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module pvt_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  input  wire logic                               in_tready,
  // vertex_x, vertex_y, vertex_z, rotation_angle, zero pad
  input  wire logic [pvt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                               out_tvalid,
  input  wire logic                               out_tready,
  // screen_x, screen_y
  input  wire logic [pvt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // behind_viewer, clipped
  input  wire logic [1:0]                         out_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [pvt_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire logic [pvt_pkg::CFG_W-1:0]          cfg_wdata,
  output int                                      fail_count,
  output int                                      pending_pixels,
  output int                                      behind_seen,
  output int                                      clipped_seen
);
  import pvt_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
    logic                    behind;
    logic                    clipped;
  } pixel_t;

  pixel_t pixel_q[$];

  logic signed [DEPTH_W-1:0] depth_offset;
  logic [DIM_W-1:0]          screen_width;
  logic [DIM_W-1:0]          screen_height;

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // quarter-wave polynomial in Q2.30, rounded to Q1.12
  function automatic longint quarter_wave(longint unsigned r);
    longint unsigned t, t2, p;
    t  = r << (30 - (ANGLE_W - 2));
    t2 = (t * t) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995 - ((t2 * p) >> 30);
    p  = 64'd85569306 - ((t2 * p) >> 30);
    p  = 64'd693598668 - ((t2 * p) >> 30);
    p  = 64'd1686629713 - ((t2 * p) >> 30);
    p  = (t * p) >> 30;
    return longint'((p + (64'd1 << 17)) >> 18);
  endfunction

  function automatic longint sine_q12(logic [ANGLE_W-1:0] a);
    logic [1:0]         q;
    longint unsigned    r;
    longint             s;
    q = a[ANGLE_W-1 -: 2];
    r = a[ANGLE_W-3:0];
    if (q[0]) r = (64'd1 << (ANGLE_W - 2)) - r;
    s = quarter_wave(r);
    return q[1] ? -s : s;
  endfunction

  function automatic longint clamp16(longint v, ref logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic pixel_t project_vertex(logic [IN_TDATA_W-1:0] d);
    pixel_t  res;
    longint  x, y, z, sn, cs, xr, zr, zt, w, h, diff, offs, sx, sy;
    logic    sat;
    x  = longint'($signed(d[0 +: COORD_W]));
    y  = longint'($signed(d[COORD_W +: COORD_W]));
    z  = longint'($signed(d[2*COORD_W +: COORD_W]));
    sn = sine_q12(d[3*COORD_W +: ANGLE_W]);
    cs = sine_q12(d[3*COORD_W +: ANGLE_W] + ANGLE_W'(1 << (ANGLE_W - 2)));
    xr = floor_quot(x * cs - z * sn + 2048, 4096);
    zr = floor_quot(x * sn + z * cs + 2048, 4096);
    zt = zr + longint'(depth_offset);
    res = '{sx: '0, sy: '0, behind: 1'b1, clipped: 1'b0};
    if (zt <= 0) return res;
    w    = longint'(screen_width);
    h    = longint'(screen_height);
    diff = w - h;
    offs = diff / 2;  // truncates toward zero
    sat  = 1'b0;
    sx   = clamp16(floor_quot((xr + zt) * h, 2 * zt) + offs, sat);
    sy   = clamp16(floor_quot((zt - y) * h, 2 * zt), sat);
    res  = '{sx: OUT_W'(sx), sy: OUT_W'(sy), behind: 1'b0, clipped: sat};
    return res;
  endfunction

  assign pending_pixels = pixel_q.size();

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst_n) begin
      depth_offset  <= 16'sd4096;
      screen_width  <= 13'd1024;
      screen_height <= 13'd768;
      pixel_q.delete();
      fail_count   <= 0;
      behind_seen  <= 0;
      clipped_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DEPTH:  depth_offset  <= cfg_wdata;
          CFG_WIDTH:  screen_width  <= cfg_wdata[DIM_W-1:0];
          CFG_HEIGHT: screen_height <= cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pixel_q.push_back(project_vertex(in_tdata));
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          $error("result transaction with no vertex outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_tuser[0]) behind_seen <= behind_seen + 1;
          if (out_tuser[1]) clipped_seen <= clipped_seen + 1;
          if (out_tdata[15:0] !== exp_px.sx || out_tdata[31:16] !== exp_px.sy ||
              out_tuser[0] !== exp_px.behind || out_tuser[1] !== exp_px.clipped) begin
            fail_count <= fail_count + 1;
            if (out_tdata[15:0] !== exp_px.sx)
              $error("screen_x exp %0d got %0d", exp_px.sx, $signed(out_tdata[15:0]));
            if (out_tdata[31:16] !== exp_px.sy)
              $error("screen_y exp %0d got %0d", exp_px.sy, $signed(out_tdata[31:16]));
            if (out_tuser[0] !== exp_px.behind)
              $error("behind_viewer exp %0b got %0b", exp_px.behind, out_tuser[0]);
            if (out_tuser[1] !== exp_px.clipped)
              $error("clipped exp %0b got %0b", exp_px.clipped, out_tuser[1]);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_perspective_vertex_transform.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_perspective_vertex_transform;
  import pvt_pkg::*;

  localparam logic [CFG_AW-1:0] CFG_UNMAPPED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [IN_TDATA_W-1:0]       in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]      out_tdata;
  logic [1:0]                  out_tuser;
  logic                        cfg_we = 1'b0;
  logic [CFG_AW-1:0]           cfg_addr = '0;
  logic [CFG_W-1:0]            cfg_wdata = '0;

  int fail_count, pending_pixels, behind_seen, clipped_seen;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles = 0;
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  perspective_vertex_transform uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_addr, .cfg_wdata
  );

  pvt_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .pending_pixels, .behind_seen, .clipped_seen
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stop sending and wait until every outstanding result is out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [ANGLE_W-1:0] ang);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, ang, z, y, x};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    sent++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($urandom());
      default: return 16'($signed($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd4096;
      3:       return 16'd8191;
      default: return 16'($urandom_range(4096, 1));
    endcase
  endfunction

  initial begin
    logic [15:0] dirs [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'h1000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, all quadrant angles and coordinate extremes
    foreach (dirs[i])
      send_vertex(dirs[i], dirs[3 - i], dirs[(i + 2) % 4], ANGLE_W'(i * 1024));
    send_vertex(16'h0000, 16'hffff, 16'h0000, 12'hfff);
    send_vertex(16'h1000, 16'h1000, 16'h1000, 12'd1);
    send_vertex(16'h0000, 16'h0000, 16'hf000, 12'd0);  // z exactly cancels depth
    send_vertex(16'h0000, 16'h0000, 16'h8000, 12'd2048);
    send_vertex(16'h7fff, 16'h8000, 16'hf001, 12'd0);  // tiny depth, saturates
    send_vertex(16'h8000, 16'h7fff, 16'hf001, 12'd0);
    drain();
    write_reg(CFG_DEPTH, 16'h8000);
    write_reg(CFG_WIDTH, 16'd0);
    write_reg(CFG_HEIGHT, 16'd8191);
    write_reg(CFG_UNMAPPED, 16'hffff);
    send_vertex(16'h0000, 16'h0000, 16'h7fff, 12'd0);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 12'd3072);
    drain();
    write_reg(CFG_DEPTH, 16'h7fff);
    write_reg(CFG_WIDTH, 16'd4096);
    write_reg(CFG_HEIGHT, 16'd0);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 12'd0);
    send_vertex(16'h7fff, 16'h7fff, 16'h8000, 12'd1024);
    drain();
    write_reg(CFG_HEIGHT, 16'd1);
    send_vertex(16'h1234, 16'hedcb, 16'h0100, 12'd512);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin tx_idle_pct = 13; rx_idle_pct = 63; end
        1: begin tx_idle_pct = 63; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      drain();
      @(posedge clk);
      case ($urandom_range(3))
        0:       write_reg(CFG_DEPTH, 16'($urandom()));
        1:       write_reg(CFG_DEPTH, 16'h8000 ^ 16'(ph[0] ? 16'hffff : 0));
        default: write_reg(CFG_DEPTH, 16'($urandom_range(24576, 4096)));
      endcase
      write_reg(CFG_WIDTH, ph == 0 ? 16'd1024 : rand_dim());
      write_reg(CFG_HEIGHT, ph == 0 ? 16'd768 : rand_dim());
      for (int n = 0; n < 215; n++) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord(), ANGLE_W'($urandom()));
        if (n == 100 && ph == 2) begin
          drain();
        end
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("%0d vertices over several depth/screen settings and handshake mixes", sent);
    $display("%0d behind the viewer, %0d saturated", behind_seen, clipped_seen);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending_pixels != 0) $error("%0d results never arrived", pending_pixels);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
